// File: src/utfe_pkg.sv
// Shared types for the UTF-16 to UTF-8 encoder.
package utfe_pkg;

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW     = 3;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;  // bytes[0] goes out first
    logic [CntW-1:0]          count;  // 1..MaxBytes
    logic                     term;   // last byte is the zero terminator
  } entry_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// File: src/utf16_to_utf8_encoder.sv
// A request is first written into the queue; its first byte is then loaded into the output register.
// The back end sends one output byte per cycle while out_ready_i is high; a unit's bytes go out in order.
// The input is taken whenever the request queue (QueueDepth entries) has room, so a
// held high surrogate pushes no request and input runs ahead of the byte stream.
// Reset (async, active low) empties the queue and output and drops any held surrogate.
module utf16_to_utf8_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  utf8_byte_o,
  output logic        last_of_run_o,
  output logic        string_end_o
);
  import utfe_pkg::*;

  hs_t    push;
  entry_t wr_entry, rd_entry;
  logic   full_n, q_valid, q_pop;

  utfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .push_o       (push),
    .push_ready_i (full_n),
    .entry_o      (wr_entry)
  );

  utfe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wr_entry_i (wr_entry),
    .full_n_o   (full_n),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .rd_entry_o (rd_entry)
  );

  utfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (rd_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .utf8_byte_o   (utf8_byte_o),
    .last_of_run_o (last_of_run_o),
    .string_end_o  (string_end_o)
  );

endmodule

// File: src/utfe_front.sv
// Front end: accepts code units, pairs surrogates and builds the byte list of each request.
module utfe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [15:0]     code_unit_i,
  output utfe_pkg::hs_t   push_o,
  input  logic            push_ready_i,
  output utfe_pkg::entry_t entry_o
);
  import utfe_pkg::*;

  logic [9:0]  held_high_q, held_high_d;
  logic        held_valid_q, held_valid_d;
  logic        accept;
  logic        is_high, is_low;
  logic [10:0] plane;
  logic [20:0] cp;
  logic [2:0][7:0] main_b, flush_b;
  logic [CntW-1:0] main_cnt;
  logic        main_term;
  logic [15:0] held_unit;

  function automatic logic [2:0][7:0] three_bytes(input logic [15:0] u);
    logic [2:0][7:0] r;
    r[0] = {4'hE, u[15:12]};
    r[1] = {2'b10, u[11:6]};
    r[2] = {2'b10, u[5:0]};
    return r;
  endfunction

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = push_ready_i;
  assign is_high   = code_unit_i[15:10] == 6'b110110;
  assign is_low    = code_unit_i[15:10] == 6'b110111;
  assign held_unit = {6'b110110, held_high_q};
  assign plane     = {1'b0, held_high_q} + 11'h040;
  assign cp        = {plane, code_unit_i[9:0]};
  assign flush_b   = three_bytes(held_unit);

  always_comb begin
    main_b    = '0;
    main_cnt  = '0;
    main_term = 1'b0;
    if (code_unit_i == 16'h0000) begin
      main_cnt  = CntW'(1);
      main_term = 1'b1;
    end else if (code_unit_i[15:7] == '0) begin
      main_b[0] = code_unit_i[7:0];
      main_cnt  = CntW'(1);
    end else if (code_unit_i[15:11] == '0) begin
      main_b[0] = {3'b110, code_unit_i[10:6]};
      main_b[1] = {2'b10, code_unit_i[5:0]};
      main_cnt  = CntW'(2);
    end else if (!is_high) begin
      main_b   = three_bytes(code_unit_i);
      main_cnt = CntW'(3);
    end
  end

  always_comb begin
    entry_o      = '0;
    held_high_d  = held_high_q;
    held_valid_d = held_valid_q;
    if (held_valid_q && is_low) begin
      entry_o.bytes[0] = {5'b11110, cp[20:18]};
      entry_o.bytes[1] = {2'b10, cp[17:12]};
      entry_o.bytes[2] = {2'b10, cp[11:6]};
      entry_o.bytes[3] = {2'b10, cp[5:0]};
      entry_o.count    = CntW'(4);
    end else if (held_valid_q) begin
      entry_o.bytes[2:0] = flush_b;
      entry_o.bytes[5:3] = main_b;
      entry_o.count      = main_cnt + CntW'(3);
      entry_o.term       = main_term;
    end else begin
      entry_o.bytes[2:0] = main_b;
      entry_o.count      = main_cnt;
      entry_o.term       = main_term;
    end
    if (accept) begin
      if (held_valid_q && is_low) begin
        held_valid_d = 1'b0;
        held_high_d  = '0;
      end else if (is_high) begin
        held_valid_d = 1'b1;
        held_high_d  = code_unit_i[9:0];
      end else begin
        held_valid_d = 1'b0;
        held_high_d  = '0;
      end
    end
  end

  assign push_o.valid = accept && (entry_o.count != '0);
  assign push_o.ready = push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_high_q  <= '0;
      held_valid_q <= 1'b0;
    end else begin
      held_high_q  <= held_high_d;
      held_valid_q <= held_valid_d;
    end
  end

endmodule

// File: src/utfe_fifo.sv
// Short request queue between the front and back ends.
module utfe_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  utfe_pkg::hs_t    push_i,
  input  utfe_pkg::entry_t wr_entry_i,
  output logic             full_n_o,
  output logic             valid_o,
  input  logic             pop_i,
  output utfe_pkg::entry_t rd_entry_o
);
  import utfe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0] level_q, level_d;
  logic            do_push, do_pop;

  assign full_n_o   = level_q != LvlW'(Depth);
  assign valid_o    = level_q != '0;
  assign do_push    = push_i.valid && full_n_o;
  assign do_pop     = pop_i && valid_o;
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      level_d = level_q + LvlW'(1);
    end else if (do_pop && !do_push) begin
      level_d = level_q - LvlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

// File: src/utfe_back.sv
// Back end: streams the bytes of each queued request through the output register.
module utfe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  utfe_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       utf8_byte_o,
  output logic             last_of_run_o,
  output logic             string_end_o
);
  import utfe_pkg::*;

  logic [CntW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d, end_q, end_d;
  logic            load, is_last;

  assign load    = q_valid_i && (!valid_q || out_ready_i);
  assign is_last = idx_q == (q_entry_i.count - CntW'(1));
  assign q_pop_o = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q && !out_ready_i;
    byte_d  = byte_q;
    last_d  = last_q;
    end_d   = end_q;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = q_entry_i.bytes[idx_q];
      last_d  = is_last;
      end_d   = is_last && q_entry_i.term;
      idx_d   = is_last ? '0 : idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    end_q  <= end_d;
  end

  assign out_valid_o   = valid_q;
  assign utf8_byte_o   = byte_q;
  assign last_of_run_o = last_q;
  assign string_end_o  = end_q;

endmodule

// File: sim/utf16_to_utf8_encoder_tb.sv
// Self-checking bench: random-paced UTF-16 units into the encoder, UTF-8 bytes checked in order.
module utf16_to_utf8_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned NumDirected = 25;
  localparam int unsigned NumRandom   = 135;
  localparam int unsigned SettleWait  = 20;
  localparam logic [5:0]  HiSurTag    = 6'b110110;
  localparam logic [5:0]  LoSurTag    = 6'b110111;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       term;
  } utf8_out_t;

  // typed rows carry their bytes, the rest go through the predictor
  typedef struct packed {
    logic [15:0]                              unit;
    logic                                     typed;
    logic [2:0]                               nb;
    logic [0:utfe_pkg::MaxBytes-1][7:0]       bytes;
  } unit_row_t;

  logic        clk;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] code_unit_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  utf8_byte_o;
  logic        last_of_run_o;
  logic        string_end_o;

  utf8_out_t   pending_utf8[$];
  logic [9:0]  held_hi;
  logic        holding_hi;
  bit          calm;
  int          errors;
  int          idle_cycles;

  unit_row_t unit_rows [NumDirected] = '{
    '{16'h0000, 1'b1, 3'd1, 48'h00_00_00_00_00_00},
    '{16'h0001, 1'b0, 3'd0, 48'h0},
    '{16'h007F, 1'b1, 3'd1, 48'h7F_00_00_00_00_00},
    '{16'h0080, 1'b1, 3'd2, 48'hC2_80_00_00_00_00},
    '{16'h07FF, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00},
    '{16'h0800, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00},
    '{16'h1234, 1'b0, 3'd0, 48'h0},
    '{16'hFFFF, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00},
    '{16'hD800, 1'b1, 3'd0, 48'h0},
    '{16'hDC00, 1'b1, 3'd4, 48'hF0_90_80_80_00_00},
    '{16'hDBFF, 1'b1, 3'd0, 48'h0},
    '{16'hDFFF, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00},
    '{16'hDC00, 1'b1, 3'd3, 48'hED_B0_80_00_00_00},
    '{16'hD812, 1'b0, 3'd0, 48'h0},
    '{16'h0041, 1'b0, 3'd0, 48'h0},
    '{16'hD9AA, 1'b0, 3'd0, 48'h0},
    '{16'h0000, 1'b0, 3'd0, 48'h0},
    '{16'hDABC, 1'b0, 3'd0, 48'h0},
    '{16'hDB01, 1'b0, 3'd0, 48'h0},
    '{16'hDC55, 1'b0, 3'd0, 48'h0},
    '{16'hD800, 1'b0, 3'd0, 48'h0},
    '{16'h07FF, 1'b0, 3'd0, 48'h0},
    '{16'hA5A5, 1'b0, 3'd0, 48'h0},
    '{16'h5A5A, 1'b0, 3'd0, 48'h0},
    '{16'hE000, 1'b0, 3'd0, 48'h0}
  };

  utf16_to_utf8_encoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_unit_i   (code_unit_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .utf8_byte_o   (utf8_byte_o),
    .last_of_run_o (last_of_run_o),
    .string_end_o  (string_end_o)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // --- predictor ---
  function automatic void put_utf8(input logic [7:0] b, input logic term);
    pending_utf8.push_back(utf8_out_t'{b, 1'b0, term});
  endfunction

  function automatic void put_three(input logic [15:0] u);
    put_utf8({4'hE, u[15:12]}, 1'b0);
    put_utf8({2'b10, u[11:6]}, 1'b0);
    put_utf8({2'b10, u[5:0]}, 1'b0);
  endfunction

  function automatic void encode_unit(input logic [15:0] u);
    int          start_sz;
    logic [20:0] cp;
    start_sz = pending_utf8.size();
    if (holding_hi && u[15:10] == LoSurTag) begin
      cp = 21'h10000 + {1'b0, held_hi, u[9:0]};
      put_utf8({5'b11110, cp[20:18]}, 1'b0);
      put_utf8({2'b10, cp[17:12]}, 1'b0);
      put_utf8({2'b10, cp[11:6]}, 1'b0);
      put_utf8({2'b10, cp[5:0]}, 1'b0);
      holding_hi = 1'b0;
      held_hi    = '0;
    end else begin
      if (holding_hi) begin
        put_three({HiSurTag, held_hi});
        holding_hi = 1'b0;
        held_hi    = '0;
      end
      if (u == 16'h0000) begin
        put_utf8(8'h00, 1'b1);
      end else if (u[15:7] == '0) begin
        put_utf8(u[7:0], 1'b0);
      end else if (u[15:11] == '0) begin
        put_utf8({3'b110, u[10:6]}, 1'b0);
        put_utf8({2'b10, u[5:0]}, 1'b0);
      end else if (u[15:10] == HiSurTag) begin
        held_hi    = u[9:0];
        holding_hi = 1'b1;
      end else begin
        put_three(u);
      end
    end
    if (pending_utf8.size() > start_sz) pending_utf8[pending_utf8.size()-1].last = 1'b1;
  endfunction

  // --- output side ---
  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    utf8_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_utf8.size() == 0) begin
        $display("%0t: unexpected byte %h last %b end %b", $time,
                 utf8_byte_o, last_of_run_o, string_end_o);
        errors++;
      end else begin
        want = pending_utf8.pop_front();
        if (want.b !== utf8_byte_o || want.last !== last_of_run_o ||
            want.term !== string_end_o) begin
          $display("%0t: expected byte %h last %b end %b, got byte %h last %b end %b",
                   $time, want.b, want.last, want.term,
                   utf8_byte_o, last_of_run_o, string_end_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("utf16_to_utf8_encoder_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --- input side: entered and left at a falling edge ---
  task automatic send_unit(input unit_row_t row);
    int sz;
    int gap;
    in_valid_i  <= 1'b1;
    code_unit_i <= row.unit;
    do @(posedge clk); while (!in_ready_o);
    sz = pending_utf8.size();
    encode_unit(row.unit);
    if (row.typed) begin
      while (pending_utf8.size() > sz) void'(pending_utf8.pop_back());
      for (int i = 0; i < row.nb; i++) begin
        pending_utf8.push_back(utf8_out_t'{row.bytes[i], i == row.nb - 1, row.unit == 16'h0});
      end
    end
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic unit_row_t plain(input logic [15:0] u);
    unit_row_t row;
    row      = '0;
    row.unit = u;
    return row;
  endfunction

  task automatic run_random();
    int         sent;
    int         kind;
    bit         drained;
    logic [15:0] u;
    sent    = 0;
    drained = 1'b0;
    while (sent < NumRandom) begin
      if (sent % 20 == 0) calm = ($urandom_range(3) == 0);
      if (!drained && sent >= NumRandom / 2) begin
        // hold off until the byte stream has caught up
        in_valid_i <= 1'b0;
        do @(negedge clk); while (pending_utf8.size() != 0);
        drained = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 20) begin
        send_unit(plain(16'($urandom)));
        sent++;
      end else if (kind < 35) begin
        send_unit(plain(16'($urandom_range(16'h7F, 16'h01))));
        sent++;
      end else if (kind < 47) begin
        send_unit(plain(16'($urandom_range(16'h7FF, 16'h80))));
        sent++;
      end else if (kind < 60) begin
        u = 16'($urandom_range(16'hFFFF, 16'h800));
        if (u[15:11] == 5'b11011) u[15:11] = 5'b11100;
        send_unit(plain(u));
        sent++;
      end else if (kind < 85) begin
        send_unit(plain({HiSurTag, 10'($urandom)}));
        send_unit(plain({LoSurTag, 10'($urandom)}));
        sent += 2;
      end else if (kind < 92) begin
        send_unit(plain({HiSurTag, 10'($urandom)}));
        u = 16'($urandom);
        if (u[15:10] == LoSurTag) u = 16'h0000;
        send_unit(plain(u));
        sent += 2;
      end else if (kind < 96) begin
        send_unit(plain({LoSurTag, 10'($urandom)}));
        sent++;
      end else begin
        send_unit(plain(16'h0000));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    code_unit_i = '0;
    held_hi     = '0;
    holding_hi  = 1'b0;
    calm        = 1'b0;
    errors      = 0;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < NumDirected; i++) send_unit(unit_rows[i]);
    run_random();
    in_valid_i <= 1'b0;
    do @(negedge clk); while (pending_utf8.size() != 0);
    repeat (SettleWait) @(negedge clk);
    if (errors == 0) begin
      $display("utf16_to_utf8_encoder_tb OK");
    end else begin
      $display("utf16_to_utf8_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule
